@@ sv/indexed_min_heap_update_defines.svh @@
// Assertion macros shared by the indexed min-heap RTL.
// Expects clk and rst_n in the scope where a macro is used; no other dependencies.
`ifndef INDEXED_MIN_HEAP_UPDATE_DEFINES_SVH
`define INDEXED_MIN_HEAP_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IHU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ihu_pkg.sv @@
// Shared constants, payload types and controller/datapath interface types
// for the indexed min-heap update block. No dependencies.
package ihu_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 32;
    localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = SLOT_BITS + 1;

    localparam logic [KEY_BITS-1:0] KEY_INFINITY = {KEY_BITS{1'b1}};

    typedef struct packed {
        logic [SLOT_BITS-1:0] entry_index;
        logic [KEY_BITS-1:0]  new_key;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] min_entry;
        logic [KEY_BITS-1:0]  min_key;
    } out_item_t;

    // One heap slot: key of the entry held there and the entry itself.
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [SLOT_BITS-1:0] entry;
    } slot_word_t;

    typedef struct packed {
        logic load_item;
        logic take_slot;
        logic rd_parent;
        logic rd_children;
        logic rd_root;
        logic move_up;
        logic move_down;
        logic write_final;
        logic load_out;
    } heap_cmd_t;

    typedef struct packed {
        logic lookup_ok;
        logic at_root;
        logic up_move;
        logic has_left;
        logic down_move;
        logic out_free;
    } heap_stat_t;

endpackage

@@ sv/ihu_dpath.sv @@
// Datapath of the indexed min-heap: slot and entry memories, sift registers,
// comparators and result register. Depends on ihu_pkg and the assertion header.
`include "indexed_min_heap_update_defines.svh"

module ihu_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ihu_pkg::in_item_t             item,
    input  logic                          cfg_we,
    input  logic [ihu_pkg::CNT_BITS-1:0]  cfg_wdata,
    input  ihu_pkg::heap_cmd_t            cmd,
    output ihu_pkg::heap_stat_t           stat,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ihu_pkg::out_item_t            result
);
    import ihu_pkg::*;

    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  n_act;
    logic [SLOT_BITS-1:0] entry_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;

    slot_word_t           slot_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] slot_vld_reg;
    logic [SLOT_BITS-1:0] e2s_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] e2s_vld_reg;

    slot_word_t           rd_a_reg;
    slot_word_t           rd_b_reg;
    logic [SLOT_BITS-1:0] e2s_q_reg;

    logic [SLOT_BITS-1:0] parent_slot;
    logic [CNT_BITS:0]    left_ext;
    logic [CNT_BITS:0]    right_ext;
    logic                 has_right;
    logic                 pick_left;
    slot_word_t           child_word;
    logic [SLOT_BITS-1:0] child_slot;

    logic                 rd_a_en;
    logic [SLOT_BITS-1:0] rd_a_addr;
    logic [SLOT_BITS-1:0] rd_b_addr;
    logic                 slot_we;
    slot_word_t           slot_wdata;
    logic [SLOT_BITS-1:0] e2s_waddr;

    out_item_t            result_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    // Clamp the configured count into 1..MAX_ENTRIES.
    always_comb
    begin
        priority if (cnt_reg == '0)
            n_act = CNT_BITS'(1);
        else if (cnt_reg > CNT_BITS'(MAX_ENTRIES))
            n_act = CNT_BITS'(MAX_ENTRIES);
        else
            n_act = cnt_reg;
    end

    assign parent_slot = (slot_reg - SLOT_BITS'(1)) >> 1;
    assign left_ext    = {1'b0, slot_reg, 1'b1};
    assign right_ext   = left_ext + (CNT_BITS+1)'(1);
    assign has_right   = right_ext < {1'b0, n_act};

    assign pick_left  = !has_right || (rd_a_reg.key < rd_b_reg.key);
    assign child_word = pick_left ? rd_a_reg : rd_b_reg;
    assign child_slot = pick_left ? left_ext[SLOT_BITS-1:0] : right_ext[SLOT_BITS-1:0];

    always_comb
    begin
        stat.lookup_ok = ({1'b0, entry_reg} < n_act) && ({1'b0, e2s_q_reg} < n_act);
        stat.at_root   = (slot_reg == '0);
        stat.up_move   = key_reg < rd_a_reg.key;
        stat.has_left  = left_ext < {1'b0, n_act};
        stat.down_move = key_reg > child_word.key;
        stat.out_free  = !result_valid_reg || result_ready;
    end

    // Read port A serves the parent, the left child or the root.
    assign rd_a_en   = cmd.rd_parent || cmd.rd_children || cmd.rd_root;
    always_comb
    begin
        priority if (cmd.rd_root)
            rd_a_addr = '0;
        else if (cmd.rd_parent)
            rd_a_addr = parent_slot;
        else
            rd_a_addr = left_ext[SLOT_BITS-1:0];
    end
    assign rd_b_addr = right_ext[SLOT_BITS-1:0];

    // Move the parent or chosen child into the hole, or drop the new item in.
    assign slot_we = cmd.move_up || cmd.move_down || cmd.write_final;
    always_comb
    begin
        priority if (cmd.move_up)
        begin
            slot_wdata = rd_a_reg;
        end
        else if (cmd.move_down)
        begin
            slot_wdata = child_word;
        end
        else
        begin
            slot_wdata.key   = key_reg;
            slot_wdata.entry = entry_reg;
        end
    end
    assign e2s_waddr = slot_wdata.entry;

    always_comb
    begin
        priority if (cmd.take_slot)
            slot_next = e2s_q_reg;
        else if (cmd.move_up)
            slot_next = parent_slot;
        else if (cmd.move_down)
            slot_next = child_slot;
        else
            slot_next = slot_reg;
    end

    // Memories: unwritten entries read as their reset contents.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_reg]  <= slot_wdata;
            e2s_mem[e2s_waddr]  <= slot_reg;
        end
        if (rd_a_en)
        begin
            if (slot_vld_reg[rd_a_addr])
                rd_a_reg <= slot_mem[rd_a_addr];
            else
                rd_a_reg <= '{key: KEY_INFINITY, entry: rd_a_addr};
        end
        if (cmd.rd_children)
        begin
            if (slot_vld_reg[rd_b_addr])
                rd_b_reg <= slot_mem[rd_b_addr];
            else
                rd_b_reg <= '{key: KEY_INFINITY, entry: rd_b_addr};
        end
        if (cmd.load_item)
        begin
            if (e2s_vld_reg[item.entry_index])
                e2s_q_reg <= e2s_mem[item.entry_index];
            else
                e2s_q_reg <= item.entry_index;
            entry_reg <= item.entry_index;
            key_reg   <= item.new_key;
        end
        if (cmd.load_out)
        begin
            result_reg.min_entry <= rd_a_reg.entry;
            result_reg.min_key   <= rd_a_reg.key;
        end
        slot_reg <= slot_next;
    end

    assign result_valid_next = cmd.load_out || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= CNT_BITS'(MAX_ENTRIES);
            slot_vld_reg     <= '0;
            e2s_vld_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cnt_reg <= cfg_wdata;
            if (slot_we)
            begin
                slot_vld_reg[slot_reg] <= 1'b1;
                e2s_vld_reg[e2s_waddr] <= 1'b1;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `IHU_ASSERT_IMP(a_down_has_child, cmd.move_down, stat.has_left, "move down without a child")
    `IHU_ASSERT_IMP(a_write_in_range, slot_we, ({1'b0, slot_reg} < n_act), "write beyond active slots")
    `IHU_ASSERT_IMP(a_load_out_free, cmd.load_out, stat.out_free, "result overwritten while held")

endmodule

@@ sv/ihu_ctrl.sv @@
// Sequencer for the indexed min-heap: steps lookup, sift up or down, write-back
// and root read. Depends on ihu_pkg and the assertion header.
`include "indexed_min_heap_update_defines.svh"

module ihu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  ihu_pkg::heap_stat_t stat,
    output ihu_pkg::heap_cmd_t  cmd
);
    import ihu_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOOKUP    = 4'd1;
    localparam logic [3:0] S_PAR_RD    = 4'd2;
    localparam logic [3:0] S_UP_CMP    = 4'd3;
    localparam logic [3:0] S_DN_RD     = 4'd4;
    localparam logic [3:0] S_DN_CMP    = 4'd5;
    localparam logic [3:0] S_FINAL     = 4'd6;
    localparam logic [3:0] S_ROOT_RD   = 4'd7;
    localparam logic [3:0] S_ROOT_WAIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       climbed_reg;
    logic       climbed_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        climbed_next = climbed_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    climbed_next  = 1'b0;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (stat.lookup_ok)
                begin
                    cmd.take_slot = 1'b1;
                    state_next    = S_PAR_RD;
                end
                else
                begin
                    state_next = S_ROOT_RD;
                end
            end
            S_PAR_RD:
            begin
                if (!stat.at_root)
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
                else if (climbed_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd.move_up  = 1'b1;
                    climbed_next = 1'b1;
                    state_next   = S_PAR_RD;
                end
                else if (climbed_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                if (stat.has_left)
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DN_CMP:
            begin
                if (stat.down_move)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.write_final = 1'b1;
                state_next      = S_ROOT_RD;
            end
            S_ROOT_RD:
            begin
                cmd.rd_root = 1'b1;
                state_next  = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            climbed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            climbed_reg <= climbed_next;
        end
    end

    `IHU_ASSERT_NXT(a_accept_lookup, item_valid && item_ready, state_reg == S_LOOKUP, "accept did not start lookup")
    `IHU_ASSERT_IMP(a_one_write, 1'b1, $onehot0({cmd.move_up, cmd.move_down, cmd.write_final}), "two slot writes at once")
    `IHU_ASSERT_IMP(a_one_read, 1'b1, $onehot0({cmd.rd_parent, cmd.rd_children, cmd.rd_root}), "two port A reads at once")

endmodule

@@ sv/indexed_min_heap_update.sv @@
// Top level of the indexed min-heap update block: controller plus datapath.
// Depends on ihu_pkg, ihu_ctrl and ihu_dpath.
//
// Usage:
//   item channel (item_valid/item_ready/item): one transfer names an entry and
//   its new key; all-ones key means the entry never fires.
//   result channel (result_valid/result_ready/result): one transfer per item,
//   carrying the entry at the heap root and its key after the update.
//   cfg_we/cfg_wdata: write entries_in_use (0 acts as 1, above 64 as 64);
//   write only while the block is idle.
// Sequence: an ignored update goes from the lookup straight to the root read;
//   otherwise the entry is sifted up or down a level at a time, written into
//   its final slot, and then the root is read. Each level crossed costs a
//   registered read of the slot memory and a compare-and-move step.
// Throughput: one item at a time; item_ready is high only while the
//   sequencer idles, which it reenters as soon as the result register loads.
// Reset: keys read as infinity, entry k sits in slot k, 64 entries active;
//   no clearing pass is needed, per-slot valid bits supply the reset contents.
// Stall: a held result stays in its register while the next item is taken
//   and sifted; the block only waits at the very end for the register to free.
module indexed_min_heap_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ihu_pkg::in_item_t             item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ihu_pkg::out_item_t            result,
    input  logic                          cfg_we,
    input  logic [ihu_pkg::CNT_BITS-1:0]  cfg_wdata
);
    import ihu_pkg::*;

    heap_cmd_t  cmd;
    heap_stat_t stat;

    // Sequence each transfer through lookup, sift and root read.
    ihu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Hold the heap, move entries and register the result.
    ihu_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
